>>> hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, command/status bundles between the controller and datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

   localparam int FRAMES      = 16;
   localparam int FRAME_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W      = FRAME_W;
   localparam int OLD_W       = RANK_W + 1;
   localparam int PAGE_W      = 16;
   localparam int FRAME_OUT_W = 4;
   localparam int FAULT_W     = 32;
   localparam int CFG_W       = 5;
   localparam int ACT_W       = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

   // victim search: ranks are reduced in groups, then across groups
   localparam int GRP         = 4;
   localparam int GROUPS      = (FRAMES + GRP - 1) / GRP;

   typedef struct packed {
      logic capture;   // latch request page
      logic scan;      // compare and group reduce
      logic pick;      // choose frame
      logic commit;    // update state, load response
   } lpr_cmd_type;

   typedef struct packed {
      logic slot_free; // response register can take a new transaction
   } lpr_status_type;

endpackage

>>> hdl/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative frame set with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+------------------
//  req     | req_page_number                | in        | req_valid/ready
//  rsp     | rsp_hit .. rsp_fault_total     | out       | rsp_valid/ready
//  csr     | csr_wr_data (frames in use)    | in        | csr_wr_en
//
//  An item goes through accept, parallel compare with group rank reduce,
//  frame pick, then rank/state commit into the response register.
//  Commit waits while the previous response is still held by rsp_ready low.
//  Reset clears all frame valid bits and the fault count; frames_in_use = 16.
// ----------------------------------------------------------------------------
module lru_page_replacement_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lpr_pkg::PAGE_W-1:0]          req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [lpr_pkg::FRAME_OUT_W-1:0]     rsp_frame_used,
   output logic                                rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_W-1:0]          rsp_evicted_page,
   output logic [lpr_pkg::FAULT_W-1:0]         rsp_fault_total,
   input  logic                                csr_wr_en,
   input  logic [lpr_pkg::CFG_W-1:0]           csr_wr_data
);

   lpr_pkg::lpr_cmd_type    cmd;
   lpr_pkg::lpr_status_type status;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_used    (rsp_frame_used),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule

>>> hdl/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences one reference through scan, pick and commit.
// ----------------------------------------------------------------------------
module lpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lpr_pkg::lpr_status_type status,
   output lpr_pkg::lpr_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_PICK   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the previous response has drained
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/lpr_datapath.sv
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Frame table, recency ranks, fault counter, config and response register.
// ----------------------------------------------------------------------------
module lpr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lpr_pkg::lpr_cmd_type                cmd,
   output lpr_pkg::lpr_status_type             status,
   input  logic                                csr_wr_en,
   input  logic [lpr_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic [lpr_pkg::PAGE_W-1:0]          req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [lpr_pkg::FRAME_OUT_W-1:0]     rsp_frame_used,
   output logic                                rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_W-1:0]          rsp_evicted_page,
   output logic [lpr_pkg::FAULT_W-1:0]         rsp_fault_total
);

   // frame state
   logic                         valid_ff [lpr_pkg::FRAMES];
   logic                         valid_in [lpr_pkg::FRAMES];
   logic [lpr_pkg::PAGE_W-1:0]   page_ff  [lpr_pkg::FRAMES];
   logic [lpr_pkg::RANK_W-1:0]   rank_ff  [lpr_pkg::FRAMES];
   logic [lpr_pkg::RANK_W-1:0]   rank_in  [lpr_pkg::FRAMES];
   logic [lpr_pkg::FAULT_W-1:0]  fault_ff, fault_in;
   logic [lpr_pkg::CFG_W-1:0]    cfg_ff;

   // request and scan results
   logic [lpr_pkg::PAGE_W-1:0]   req_page_ff;
   logic                         hit_ff, hit_in;
   logic [lpr_pkg::FRAME_W-1:0]  hit_idx_ff, hit_idx_in;
   logic                         empty_ff, empty_in;
   logic [lpr_pkg::FRAME_W-1:0]  empty_idx_ff, empty_idx_in;
   logic [lpr_pkg::RANK_W-1:0]   grp_rank_ff [lpr_pkg::GROUPS];
   logic [lpr_pkg::RANK_W-1:0]   grp_rank_in [lpr_pkg::GROUPS];
   logic [lpr_pkg::FRAME_W-1:0]  grp_idx_ff  [lpr_pkg::GROUPS];
   logic [lpr_pkg::FRAME_W-1:0]  grp_idx_in  [lpr_pkg::GROUPS];
   logic                         grp_ok_ff   [lpr_pkg::GROUPS];
   logic                         grp_ok_in   [lpr_pkg::GROUPS];

   // chosen frame
   logic [lpr_pkg::FRAME_W-1:0]  sel_idx_ff, sel_idx_in;
   logic                         sel_hit_ff;
   logic                         sel_evict_ff, sel_evict_in;
   logic [lpr_pkg::OLD_W-1:0]    sel_old_ff, sel_old_in;
   logic [lpr_pkg::PAGE_W-1:0]   sel_page_ff, sel_page_in;

   // response register
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   logic [lpr_pkg::FRAME_OUT_W-1:0]    rsp_frame_ff;
   logic                               rsp_evict_ff;
   logic [lpr_pkg::PAGE_W-1:0]         rsp_epage_ff;
   logic [lpr_pkg::FAULT_W-1:0]        rsp_fault_ff;

   logic [lpr_pkg::ACT_W-1:0]    act_n;
   logic                         active [lpr_pkg::FRAMES];

   // active frame count, clamped to 1..FRAMES
   always_comb begin
      if (cfg_ff == '0) begin
         act_n = lpr_pkg::ACT_W'(1);
      end else if (lpr_pkg::ACT_W'(cfg_ff) > lpr_pkg::ACT_W'(lpr_pkg::FRAMES)) begin
         act_n = lpr_pkg::ACT_W'(lpr_pkg::FRAMES);
      end else begin
         act_n = lpr_pkg::ACT_W'(cfg_ff);
      end
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
         active[j] = lpr_pkg::ACT_W'(j) < act_n;
      end
   end

   // scan: lowest matching frame, lowest empty frame, per-group oldest rank
   always_comb begin
      hit_in       = 1'b0;
      hit_idx_in   = '0;
      empty_in     = 1'b0;
      empty_idx_in = '0;
      for (int j = lpr_pkg::FRAMES - 1; j >= 0; j--) begin
         if (active[j] && valid_ff[j] && page_ff[j] == req_page_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = lpr_pkg::FRAME_W'(j);
         end
         if (active[j] && !valid_ff[j]) begin
            empty_in     = 1'b1;
            empty_idx_in = lpr_pkg::FRAME_W'(j);
         end
      end
      for (int g = 0; g < lpr_pkg::GROUPS; g++) begin
         grp_ok_in[g]   = 1'b0;
         grp_rank_in[g] = '0;
         grp_idx_in[g]  = '0;
         for (int k = 0; k < lpr_pkg::GRP; k++) begin
            if (g * lpr_pkg::GRP + k < lpr_pkg::FRAMES) begin
               // strict compare keeps the lowest index on a tie
               if (active[g * lpr_pkg::GRP + k] &&
                   (!grp_ok_in[g] || rank_ff[g * lpr_pkg::GRP + k] > grp_rank_in[g])) begin
                  grp_ok_in[g]   = 1'b1;
                  grp_rank_in[g] = rank_ff[g * lpr_pkg::GRP + k];
                  grp_idx_in[g]  = lpr_pkg::FRAME_W'(g * lpr_pkg::GRP + k);
               end
            end
         end
      end
   end

   // pick: reduce groups, select frame and its prior rank
   always_comb begin
      logic [lpr_pkg::RANK_W-1:0]  v_rank;
      logic [lpr_pkg::FRAME_W-1:0] v_idx;
      v_rank = grp_rank_ff[0];
      v_idx  = grp_idx_ff[0];
      for (int g = 1; g < lpr_pkg::GROUPS; g++) begin
         if (grp_ok_ff[g] && grp_rank_ff[g] > v_rank) begin
            v_rank = grp_rank_ff[g];
            v_idx  = grp_idx_ff[g];
         end
      end
      sel_evict_in = 1'b0;
      sel_page_in  = '0;
      if (hit_ff) begin
         sel_idx_in = hit_idx_ff;
         sel_old_in = {1'b0, rank_ff[hit_idx_ff]};
      end else if (empty_ff) begin
         sel_idx_in = empty_idx_ff;
         sel_old_in = lpr_pkg::OLD_W'(lpr_pkg::FRAMES);
      end else begin
         sel_idx_in   = v_idx;
         sel_old_in   = {1'b0, v_rank};
         sel_evict_in = 1'b1;
         sel_page_in  = page_ff[v_idx];
      end
   end

   // commit: age younger valid frames, refresh chosen frame, count a fault on a miss
   always_comb begin
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
         rank_in[j]  = rank_ff[j];
         valid_in[j] = valid_ff[j];
         if (lpr_pkg::FRAME_W'(j) == sel_idx_ff) begin
            rank_in[j]  = '0;
            valid_in[j] = 1'b1;
         end else if (valid_ff[j] && {1'b0, rank_ff[j]} < sel_old_ff &&
                      rank_ff[j] < lpr_pkg::RANK_W'(lpr_pkg::FRAMES - 1)) begin
            rank_in[j] = rank_ff[j] + 1'b1;
         end
      end
      fault_in = fault_ff;
      if (!sel_hit_ff && fault_ff != '1) begin
         fault_in = fault_ff + 1'b1;
      end
   end

   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
            valid_ff[j] <= 1'b0;
         end
         fault_ff     <= '0;
         cfg_ff       <= lpr_pkg::CFG_W'(lpr_pkg::FRAMES);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            valid_ff     <= valid_in;
            fault_ff     <= fault_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_page_ff <= req_page_number;
      end
      if (cmd.scan) begin
         hit_ff       <= hit_in;
         hit_idx_ff   <= hit_idx_in;
         empty_ff     <= empty_in;
         empty_idx_ff <= empty_idx_in;
         grp_rank_ff  <= grp_rank_in;
         grp_idx_ff   <= grp_idx_in;
         grp_ok_ff    <= grp_ok_in;
      end
      if (cmd.pick) begin
         sel_idx_ff   <= sel_idx_in;
         sel_hit_ff   <= hit_ff;
         sel_evict_ff <= sel_evict_in;
         sel_old_ff   <= sel_old_in;
         sel_page_ff  <= sel_page_in;
      end
      if (cmd.commit) begin
         rank_ff <= rank_in;
         if (!sel_hit_ff) begin
            page_ff[sel_idx_ff] <= req_page_ff;
         end
         rsp_hit_ff   <= sel_hit_ff;
         rsp_frame_ff <= lpr_pkg::FRAME_OUT_W'(sel_idx_ff);
         rsp_evict_ff <= sel_evict_ff;
         rsp_epage_ff <= sel_page_ff;
         rsp_fault_ff <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_used    = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evict_ff;
   assign rsp_evicted_page  = rsp_epage_ff;
   assign rsp_fault_total   = rsp_fault_ff;

endmodule

>>> hdl/lpr_checker.sv
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module lpr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_hit,
   input logic                                rsp_evicted_valid,
   input logic [lpr_pkg::PAGE_W-1:0]          rsp_evicted_page,
   input logic [lpr_pkg::FAULT_W-1:0]         rsp_fault_total
);

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("hit reported an eviction");

   // evicted page reads zero unless an eviction happened
   a_epage_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   // a miss has been counted
   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_fault_total != '0)
      else $error("miss with zero fault total");

   // one transaction in flight: input closes right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_total))
      else $error("response dropped or changed while stalled");

endmodule

bind lru_page_replacement_core lpr_checker u_lpr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page),
   .rsp_fault_total   (rsp_fault_total)
);
